[hw/rtl/assert_macros.svh]
// assertion macros used by the generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define RCPG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rcpg assertion failed");

// antecedent in this cycle implies consequent in the next one
`define RCPG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcpg assertion failed");

`else

`define RCPG_ASSERT(lbl, clk, rst, prop)
`define RCPG_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/rcpg_pkg.sv]
// shared types and constants of the cyclic permutation generator
`timescale 1ns / 1ps

package rcpg_pkg;

   localparam int POS_W   = 10;
   localparam int COUNT_W = 11;
   localparam int RNG_W   = 64;

   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [RNG_W-1:0]   rng_type;

   localparam rng_type   RNG_SEED    = 64'hDEAD_BEEF_00C0_FFEE;
   localparam int        RNG_SHIFT_A = 13;
   localparam int        RNG_SHIFT_B = 17;
   localparam int        RNG_SHIFT_C = 5;
   localparam count_type COUNT_RESET = 11'd1024;

   localparam logic CMD_SHUFFLE = 1'b0;
   localparam logic CMD_LINK    = 1'b1;

endpackage

[hw/rtl/rcpg_if.sv]
// valid/ready channel interfaces for request, response and csr write
`timescale 1ns / 1ps

interface rcpg_req_if import rcpg_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    command;
   pos_type position;

   modport source (output valid, output command, output position, input ready);
   modport sink   (input valid, input command, input position, output ready);
endinterface

interface rcpg_rsp_if import rcpg_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type first_index;
   pos_type second_index;
   logic    error;

   modport source (output valid, output first_index, output second_index,
                   output error, input ready);
   modport sink   (input valid, input first_index, input second_index,
                   input error, output ready);
endinterface

interface rcpg_csr_if import rcpg_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type element_count;

   modport source (output valid, output element_count, input ready);
   modport sink   (input valid, input element_count, output ready);
endinterface

[hw/rtl/random_cyclic_permutation_gen.sv]
// random cyclic permutation generator: 64-bit xorshift driven inside-out shuffle
// shuffle beat: the 64-step serial remainder, one table read, two writes and the
//   hand-off to the response register
// link beat: two table reads, a capture and the hand-off; error beat: hand-off only
// one beat in flight; the next is accepted while a response waits to be taken
// reset (sync, active high) restores the seed and count 1024 (capped at MAX_ENTRIES); table not cleared
`timescale 1ns / 1ps

`include "assert_macros.svh"

module random_cyclic_permutation_gen import rcpg_pkg::*; #(
   parameter int MAX_ENTRIES = 1024
) (
   input logic      clock,
   input logic      reset,
   rcpg_req_if.sink   req_chan,
   rcpg_rsp_if.source rsp_chan,
   rcpg_csr_if.sink   csr_chan
);

   // table address width and count clamp follow the table depth
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam count_type MAX_CNT =
      (MAX_ENTRIES > 2047) ? 11'd2047 : count_type'(MAX_ENTRIES);
   localparam count_type RESET_CNT = (MAX_CNT < COUNT_RESET) ? MAX_CNT : COUNT_RESET;
   localparam int BIT_W = $clog2(RNG_W);

   typedef logic [AW-1:0]    addr_type;
   typedef logic [BIT_W-1:0] bit_type;

   // sequencer state codes
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIV  = 4'd1;  // serial remainder
   localparam logic [3:0] ST_SRD  = 4'd2;  // read table[j]
   localparam logic [3:0] ST_SWR1 = 4'd3;  // table[i] <= moved
   localparam logic [3:0] ST_SWR2 = 4'd4;  // table[j] <= i
   localparam logic [3:0] ST_LRD1 = 4'd5;  // read table[k]
   localparam logic [3:0] ST_LRD2 = 4'd6;  // read table[next]
   localparam logic [3:0] ST_LCAP = 4'd7;  // capture second link entry
   localparam logic [3:0] ST_FIN  = 4'd8;  // hand off to response register

   function automatic rng_type xorshift(input rng_type s);
      rng_type t;
      t = s ^ (s << RNG_SHIFT_A);
      t = t ^ (t >> RNG_SHIFT_B);
      t = t ^ (t << RNG_SHIFT_C);
      return t;
   endfunction

   function automatic addr_type to_addr(input count_type v);
      logic [COUNT_W+AW-1:0] ext;
      ext = {{AW{1'b0}}, v};
      return ext[AW-1:0];
   endfunction

   logic [3:0] state_ff, state_in;
   rng_type    rng_ff, rng_in;
   rng_type    shift_ff, shift_in;     // dividend, msb first
   pos_type    rem_ff, rem_in;         // partial remainder, ends as j
   count_type  div_ff, div_in;         // i + 1
   bit_type    bit_ff, bit_in;
   pos_type    pos_ff, pos_in;
   count_type  nxt_ff, nxt_in;
   pos_type    a_ff, a_in;
   pos_type    b_ff, b_in;
   logic       err_ff, err_in;
   count_type  count_ff, count_in;

   logic       rsp_valid_ff, rsp_valid_in;
   pos_type    rsp_first_ff, rsp_first_in;
   pos_type    rsp_second_ff, rsp_second_in;
   logic       rsp_error_ff, rsp_error_in;

   // permutation table, one port each way, registered read
   pos_type    mem [MAX_ENTRIES];
   pos_type    rdata_ff;
   logic       mem_we, mem_re;
   addr_type   waddr, raddr;
   pos_type    wdata;

   logic       req_fire;
   count_type  pos_ext, pos_inc, trial;
   pos_type    moved;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.first_index  = rsp_first_ff;
   assign rsp_chan.second_index = rsp_second_ff;
   assign rsp_chan.error        = rsp_error_ff;

   assign pos_ext = {1'b0, req_chan.position};
   assign pos_inc = pos_ext + 11'd1;
   assign trial   = {rem_ff, shift_ff[RNG_W-1]};
   assign moved   = (rem_ff == pos_ff) ? pos_ff : rdata_ff;

   always_comb begin
      state_in      = state_ff;
      rng_in        = rng_ff;
      shift_in      = shift_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      bit_in        = bit_ff;
      pos_in        = pos_ff;
      nxt_in        = nxt_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      err_in        = err_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_error_in  = rsp_error_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      waddr         = to_addr({1'b0, pos_ff});
      raddr         = to_addr({1'b0, pos_ff});
      wdata         = moved;

      // count is clamped once at write time
      if (csr_chan.valid && csr_chan.ready) begin
         count_in = (csr_chan.element_count > MAX_CNT) ? MAX_CNT : csr_chan.element_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in = req_chan.position;
               if (pos_ext >= count_ff) begin
                  // out of range: state untouched, zero indices
                  a_in     = '0;
                  b_in     = '0;
                  err_in   = 1'b1;
                  state_in = ST_FIN;
               end else if (req_chan.command == CMD_SHUFFLE) begin
                  rng_in   = xorshift(rng_ff);
                  shift_in = xorshift(rng_ff);
                  rem_in   = '0;
                  div_in   = pos_inc;
                  bit_in   = bit_type'(RNG_W - 1);
                  err_in   = 1'b0;
                  state_in = ST_DIV;
               end else begin
                  // last slot wraps back to entry 0
                  nxt_in   = (pos_inc >= count_ff) ? '0 : pos_inc;
                  err_in   = 1'b0;
                  state_in = ST_LRD1;
               end
            end
         end
         ST_DIV: begin
            // restoring remainder, one dividend bit per cycle
            if (trial >= div_ff) begin
               rem_in = pos_type'(trial - div_ff);
            end else begin
               rem_in = trial[POS_W-1:0];
            end
            shift_in = shift_ff << 1;
            bit_in   = bit_ff - bit_type'(1);
            if (bit_ff == '0) begin
               state_in = ST_SRD;
            end
         end
         ST_SRD: begin
            mem_re   = 1'b1;
            raddr    = to_addr({1'b0, rem_ff});
            state_in = ST_SWR1;
         end
         ST_SWR1: begin
            // self swap writes i and never uses the read data
            mem_we   = 1'b1;
            waddr    = to_addr({1'b0, pos_ff});
            wdata    = moved;
            a_in     = rem_ff;
            b_in     = moved;
            state_in = ST_SWR2;
         end
         ST_SWR2: begin
            mem_we   = 1'b1;
            waddr    = to_addr({1'b0, rem_ff});
            wdata    = pos_ff;
            state_in = ST_FIN;
         end
         ST_LRD1: begin
            mem_re   = 1'b1;
            raddr    = to_addr({1'b0, pos_ff});
            state_in = ST_LRD2;
         end
         ST_LRD2: begin
            mem_re   = 1'b1;
            raddr    = to_addr(nxt_ff);
            a_in     = rdata_ff;
            state_in = ST_LCAP;
         end
         ST_LCAP: begin
            b_in     = rdata_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = a_ff;
               rsp_second_in = b_ff;
               rsp_error_in  = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rng_ff       <= RNG_SEED;
         count_ff     <= RESET_CNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rng_ff       <= rng_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff      <= shift_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      bit_ff        <= bit_in;
      pos_ff        <= pos_in;
      nxt_ff        <= nxt_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      err_ff        <= err_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_error_ff  <= rsp_error_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // accepted beat always leaves idle
   `RCPG_ASSERT_NEXT(a_leave_idle, clock, reset, req_fire, state_ff != ST_IDLE)
   // partial remainder stays below the divisor
   `RCPG_ASSERT(a_rem_bound, clock, reset, (state_ff != ST_DIV) || ({1'b0, rem_ff} < div_ff))
   // swap index never exceeds the shuffle position
   `RCPG_ASSERT(a_j_bound, clock, reset, (state_ff != ST_SWR2) || (rem_ff <= pos_ff))
   // error responses carry zero indices
   `RCPG_ASSERT(a_err_zero, clock, reset, !(rsp_valid_ff && rsp_error_ff) || ((rsp_first_ff == '0) && (rsp_second_ff == '0)))

endmodule

[tb/random_cyclic_permutation_gen_tb.sv]
// self-checking testbench for the random cyclic permutation generator
`timescale 1ns / 1ps

module random_cyclic_permutation_gen_tb;
   import rcpg_pkg::*;

   localparam int MAX_ENTRIES = 1024;
   localparam int ITEM_TARGET = 1050;
   // slowest beat is a shuffle, give the tail a bit more
   localparam int DRAIN_CYCLES = 80;

   // one response beat as the block should produce it
   typedef struct {
      pos_type first_index;
      pos_type second_index;
      logic    error;
   } link_beat_type;

   // mirror of the generator state plus the queue of responses still owed
   class perm_tracker;
      rng_type       rng_state;
      count_type     count_reg;
      pos_type       slots [MAX_ENTRIES];
      bit            written [MAX_ENTRIES];
      link_beat_type expected_beats [$];
      int            mismatches;

      function new();
         rng_state = RNG_SEED;
         count_reg = COUNT_RESET;
         mismatches = 0;
         foreach (slots[n]) begin
            slots[n] = '0;
            written[n] = 1'b0;
         end
      endfunction

      // counts above the table size are clamped
      function int unsigned active_count();
         return (count_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_reg);
      endfunction

      function rng_type xorshift(rng_type s);
         s ^= s << RNG_SHIFT_A;
         s ^= s >> RNG_SHIFT_B;
         s ^= s << RNG_SHIFT_C;
         return s;
      endfunction

      // swap index the next in-range shuffle at pos would draw
      function int unsigned swap_index(int unsigned pos);
         int unsigned j;
         j = 32'(xorshift(rng_state) % (64'(pos) + 64'd1));
         return j;
      endfunction

      // true when a shuffle at pos reads nothing unwritten
      function bit shuffle_is_safe(int unsigned pos);
         int unsigned j;
         j = swap_index(pos);
         return (j == pos) || written[j];
      endfunction

      // true when both ends of the link at pos hold written entries
      function bit link_is_safe(int unsigned pos);
         int unsigned succ;
         succ = (pos + 1 >= active_count()) ? 0 : pos + 1;
         return written[pos] && written[succ];
      endfunction

      function void predict_beat(logic cmd, pos_type pos);
         link_beat_type beat;
         int unsigned   eff;
         int unsigned   j;
         int unsigned   succ;
         pos_type       moved;
         eff = active_count();
         beat = '{first_index: '0, second_index: '0, error: 1'b1};
         if (pos < eff) begin
            beat.error = 1'b0;
            if (cmd == CMD_SHUFFLE) begin
               j = swap_index(pos);
               rng_state = xorshift(rng_state);
               moved = (j == pos) ? pos : slots[j];
               slots[pos] = moved;
               written[pos] = 1'b1;
               slots[j] = pos;
               written[j] = 1'b1;
               beat.first_index = pos_type'(j);
               beat.second_index = moved;
            end else begin
               succ = (pos + 1 >= eff) ? 0 : pos + 1;
               beat.first_index = slots[pos];
               beat.second_index = slots[succ];
            end
         end
         expected_beats.push_back(beat);
      endfunction

      function void compare_field(string field, logic [POS_W-1:0] want,
                                  logic [POS_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_beat(pos_type first_index, pos_type second_index, logic error);
         link_beat_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %0d %0d %0b",
                     $time, first_index, second_index, error);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         compare_field("first_index", want.first_index, first_index);
         compare_field("second_index", want.second_index, second_index);
         compare_field("error", POS_W'(want.error), POS_W'(error));
      endfunction
   endclass

   logic clock;
   logic reset;

   rcpg_req_if req_bus ();
   rcpg_rsp_if rsp_bus ();
   rcpg_csr_if csr_bus ();

   perm_tracker board = new();
   int          sent_items = 0;
   // calm phases: that side never idles
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   random_cyclic_permutation_gen #(.MAX_ENTRIES(MAX_ENTRIES)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one request beat; valid stays high when no gap is drawn
   task automatic send_beat(logic cmd, pos_type pos);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.position <= pos;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.predict_beat(cmd, pos);
      sent_items++;
   endtask

   // count register write, only once every owed response is back
   task automatic write_count(count_type value);
      req_bus.valid <= 1'b0;
      while (board.expected_beats.size() != 0) @(posedge clock);
      // every beat answers, so a short pause is enough to be idle
      repeat (4) @(posedge clock);
      csr_bus.valid         <= 1'b1;
      csr_bus.element_count <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      board.count_reg = value;
   endtask

   // response side: random stalls, every beat checked against the oldest prediction
   initial begin : response_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         board.check_beat(rsp_bus.first_index, rsp_bus.second_index, rsp_bus.error);
      end
   end

   initial begin : stimulus
      int unsigned eff;
      int unsigned n;
      int unsigned pick;
      int unsigned pos;
      int unsigned tries;
      bit          found;
      count_type   value;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.command       <= CMD_SHUFFLE;
      req_bus.position      <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.element_count <= COUNT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: first shuffle is a self swap, later ones read only written slots
      send_beat(CMD_SHUFFLE, 10'd0);
      send_beat(CMD_SHUFFLE, 10'd1);
      send_beat(CMD_SHUFFLE, 10'd2);
      send_beat(CMD_SHUFFLE, 10'd3);
      send_beat(CMD_LINK, 10'd0);
      send_beat(CMD_LINK, 10'd1);
      send_beat(CMD_LINK, 10'd2);

      // short cycle: last link wraps to entry 0, positions past the count are errors
      write_count(11'd4);
      send_beat(CMD_LINK, 10'd3);
      send_beat(CMD_SHUFFLE, 10'd4);
      send_beat(CMD_LINK, 10'd1023);
      send_beat(CMD_SHUFFLE, 10'd1023);

      // zero count: everything is an error and nothing moves
      write_count(11'd0);
      send_beat(CMD_SHUFFLE, 10'd0);
      send_beat(CMD_LINK, 10'd0);

      // count beyond the table is clamped to the table size
      write_count(11'd2047);
      send_beat(CMD_SHUFFLE, 10'd4);
      send_beat(CMD_LINK, 10'd3);

      // single entry cycle links to itself
      write_count(11'd1);
      send_beat(CMD_SHUFFLE, 10'd0);
      send_beat(CMD_LINK, 10'd0);
      send_beat(CMD_LINK, 10'd1);

      // random phases: new count, mostly a clean shuffle then its links, then noise
      while (sent_items < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: value = '0;
            1: value = 11'd1;
            2: value = COUNT_RESET;
            3: value = count_type'($urandom_range(1025, 2047));
            4: value = count_type'($urandom_range(65, 1023));
            default: value = count_type'($urandom_range(2, 64));
         endcase
         write_count(value);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         eff = board.active_count();

         if (eff != 0 && $urandom_range(0, 9) < 7) begin
            // inside-out order from 0 never reads an unwritten slot
            n = (eff <= 40) ? eff : $urandom_range(8, 40);
            for (int unsigned i = 0; i < n; i++)
               send_beat(CMD_SHUFFLE, pos_type'(i));
            for (int unsigned k = 0; k < n; k++)
               if (board.link_is_safe(k))
                  send_beat(CMD_LINK, pos_type'(k));
         end

         repeat ($urandom_range(2, 12)) begin
            pick = $urandom_range(0, 2);
            if (eff == 0 || (pick == 0 && eff < MAX_ENTRIES)) begin
               // out of range position, either command
               send_beat(logic'($urandom_range(0, 1)),
                         pos_type'($urandom_range(eff, MAX_ENTRIES - 1)));
            end else begin
               // scattered shuffle or link that stays on written slots
               found = 1'b0;
               for (tries = 0; tries < 64 && !found; tries++) begin
                  pos = $urandom_range(0, eff - 1);
                  found = (pick == 2) ? board.link_is_safe(pos) : board.shuffle_is_safe(pos);
               end
               if (found)
                  send_beat((pick == 2) ? CMD_LINK : CMD_SHUFFLE, pos_type'(pos));
               else
                  send_beat(CMD_SHUFFLE, '0);
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (board.expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.expected_beats.size() == 0)
         $display("random_cyclic_permutation_gen verification clean");
      else
         $display("random_cyclic_permutation_gen verification failed");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin : watchdog
      #6_000_000;
      $display("random_cyclic_permutation_gen verification failed");
      $finish;
   end

endmodule
